/* design/xcfr_pkg.sv */
// Package for the xor-checked frame receiver
// Holds input kind codes, status codes, phase encoding, register indexes and shared types
// No dependencies
package xcfr_pkg;

  localparam int TimerBitsDefault = 32;

  localparam int KindW   = 2;
  localparam int ByteW   = 8;
  localparam int PosW    = 9;
  localparam int StatusW = 3;
  localparam int LimitW  = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;

  // input kind codes
  localparam logic [KindW-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KindW-1:0] KIND_TICK  = 2'd1;
  localparam logic [KindW-1:0] KIND_START = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] ST_BUSY    = 3'd0;
  localparam logic [StatusW-1:0] ST_OK      = 3'd1;
  localparam logic [StatusW-1:0] ST_BADHEAD = 3'd2;
  localparam logic [StatusW-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [StatusW-1:0] ST_CHECK   = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_HEAD_BYTE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FIRST_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BYTE_LIMIT  = 2'd2;

  localparam logic [ByteW-1:0]  HeadByteReset   = 8'd0;
  localparam logic [LimitW-1:0] FirstLimitReset = 32'd2000;
  localparam logic [LimitW-1:0] ByteLimitReset  = 32'd1000;

  // header is bytes 0..3, then L+1 more bytes, so the last index is L+4
  localparam logic [PosW-1:0] LenPos     = 9'd3;
  localparam logic [PosW-1:0] LastOffset = 9'd4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HEAD = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [PosW-1:0]  byte_index;
    logic [ByteW-1:0] payload_length;
    logic [ByteW-1:0] running_check;
  } state_t;

  typedef struct packed {
    logic [ByteW-1:0]   data_byte;
    logic [PosW-1:0]    position;
    logic               frame_end;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

/* design/xcfr_step.sv */
// Next-state and result logic for one word of the frame receiver
// Depends on xcfr_pkg
module xcfr_step #(
  parameter int TIMER_BITS = xcfr_pkg::TimerBitsDefault
) (
  input  xcfr_pkg::state_t                 st_i,
  input  logic [TIMER_BITS-1:0]            wait_i,
  input  logic [xcfr_pkg::KindW-1:0]       kind_i,
  input  logic [xcfr_pkg::ByteW-1:0]       rx_byte_i,
  input  logic [xcfr_pkg::ByteW-1:0]       head_byte_i,
  input  logic [xcfr_pkg::LimitW-1:0]      first_limit_i,
  input  logic [xcfr_pkg::LimitW-1:0]      byte_limit_i,
  output xcfr_pkg::state_t                 st_o,
  output logic [TIMER_BITS-1:0]            wait_o,
  output logic                             res_valid_o,
  output xcfr_pkg::result_t                res_o
);

  localparam int CmpW = (TIMER_BITS > xcfr_pkg::LimitW) ? TIMER_BITS : xcfr_pkg::LimitW;

  logic                          armed;
  logic [TIMER_BITS-1:0]         wait_inc;
  logic [xcfr_pkg::LimitW-1:0]   limit;
  logic [xcfr_pkg::ByteW-1:0]    check_nxt;
  logic [xcfr_pkg::ByteW-1:0]    len_nxt;
  logic [xcfr_pkg::PosW-1:0]     last_pos;
  logic                          is_last;

  assign armed     = (st_i.phase == xcfr_pkg::PH_HEAD) || (st_i.phase == xcfr_pkg::PH_BODY);
  assign wait_inc  = (wait_i == '1) ? wait_i : wait_i + 1'b1;
  assign limit     = (st_i.phase == xcfr_pkg::PH_HEAD) ? first_limit_i : byte_limit_i;
  assign check_nxt = st_i.running_check ^ rx_byte_i;
  assign len_nxt   = (st_i.byte_index == xcfr_pkg::LenPos) ? rx_byte_i : st_i.payload_length;
  assign last_pos  = xcfr_pkg::PosW'(len_nxt) + xcfr_pkg::LastOffset;
  assign is_last   = (st_i.byte_index >= xcfr_pkg::LastOffset) && (st_i.byte_index == last_pos);

  always_comb begin
    st_o        = st_i;
    wait_o      = wait_i;
    res_valid_o = 1'b0;
    res_o       = '{data_byte: rx_byte_i, position: st_i.byte_index,
                    frame_end: 1'b0, status: xcfr_pkg::ST_BUSY};
    case (kind_i)
      xcfr_pkg::KIND_START: begin
        st_o   = '{phase: xcfr_pkg::PH_HEAD, byte_index: '0,
                   payload_length: '0, running_check: '0};
        wait_o = '0;
      end
      xcfr_pkg::KIND_TICK: begin
        if (armed) begin
          wait_o = wait_inc;
          if (CmpW'(wait_inc) > CmpW'(limit)) begin
            res_valid_o     = 1'b1;
            res_o.data_byte = '0;
            res_o.frame_end = 1'b1;
            res_o.status    = xcfr_pkg::ST_TIMEOUT;
            st_o.phase      = xcfr_pkg::PH_IDLE;
          end
        end
      end
      xcfr_pkg::KIND_BYTE: begin
        if (armed) begin
          wait_o      = '0;
          res_valid_o = 1'b1;
          if (st_i.phase == xcfr_pkg::PH_HEAD) begin
            res_o.position = '0;
            if (rx_byte_i != head_byte_i) begin
              res_o.frame_end = 1'b1;
              res_o.status    = xcfr_pkg::ST_BADHEAD;
              st_o.phase      = xcfr_pkg::PH_IDLE;
            end else begin
              st_o.running_check = rx_byte_i;
              st_o.byte_index    = xcfr_pkg::PosW'(1);
              st_o.phase         = xcfr_pkg::PH_BODY;
            end
          end else begin
            st_o.running_check  = check_nxt;
            st_o.payload_length = len_nxt;
            if (is_last) begin
              res_o.frame_end = 1'b1;
              res_o.status    = (check_nxt == '0) ? xcfr_pkg::ST_OK : xcfr_pkg::ST_CHECK;
              st_o.phase      = xcfr_pkg::PH_IDLE;
            end else begin
              st_o.byte_index = st_i.byte_index + 1'b1;
            end
          end
        end
      end
      default: begin
        // unused kind, nothing happens
      end
    endcase
  end

endmodule

/* design/xor_checked_frame_receiver_unit.sv */
// Frame receiver top level: input register, step logic, result register, config registers
// Depends on xcfr_pkg and xcfr_step
//
// Takes one word per clock cycle (byte, tick or start) unless a held result stalls the input.
// An accepted word sits in the input register, where the single-pass step logic updates frame
// state and result; its result word goes into the result register, where it waits to be
// taken. Words follow back to back as long as results are taken. Ticks count into a TIMER_BITS
// wide saturating wait counter compared against the 32-bit limits.
module xor_checked_frame_receiver_unit #(
  parameter int TIMER_BITS = xcfr_pkg::TimerBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [xcfr_pkg::KindW-1:0]       kind_i,
  input  logic [xcfr_pkg::ByteW-1:0]       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [xcfr_pkg::ByteW-1:0]       data_byte_o,
  output logic [xcfr_pkg::PosW-1:0]        position_o,
  output logic                             frame_end_o,
  output logic [xcfr_pkg::StatusW-1:0]     status_o,
  input  logic                             cfg_we_i,
  input  logic [xcfr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [xcfr_pkg::CfgW-1:0]        cfg_wdata_i
);

  logic                           in_valid_q;
  logic [xcfr_pkg::KindW-1:0]     kind_q;
  logic [xcfr_pkg::ByteW-1:0]     rx_byte_q;
  logic                           go;

  xcfr_pkg::state_t               st_q, st_d;
  logic [TIMER_BITS-1:0]          wait_q, wait_d;

  logic [xcfr_pkg::ByteW-1:0]     head_q;
  logic [xcfr_pkg::LimitW-1:0]    first_limit_q;
  logic [xcfr_pkg::LimitW-1:0]    byte_limit_q;

  logic                           res_valid;
  xcfr_pkg::result_t              res_d, res_q;
  logic                           out_valid_q;

  assign go         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q    <= kind_i;
      rx_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= xcfr_pkg::HeadByteReset;
      first_limit_q <= xcfr_pkg::FirstLimitReset;
      byte_limit_q  <= xcfr_pkg::ByteLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        xcfr_pkg::REG_HEAD_BYTE:   head_q        <= cfg_wdata_i[xcfr_pkg::ByteW-1:0];
        xcfr_pkg::REG_FIRST_LIMIT: first_limit_q <= cfg_wdata_i[xcfr_pkg::LimitW-1:0];
        xcfr_pkg::REG_BYTE_LIMIT:  byte_limit_q  <= cfg_wdata_i[xcfr_pkg::LimitW-1:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  xcfr_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .st_i          (st_q),
    .wait_i        (wait_q),
    .kind_i        (kind_q),
    .rx_byte_i     (rx_byte_q),
    .head_byte_i   (head_q),
    .first_limit_i (first_limit_q),
    .byte_limit_i  (byte_limit_q),
    .st_o          (st_d),
    .wait_o        (wait_d),
    .res_valid_o   (res_valid),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '{phase: xcfr_pkg::PH_IDLE, byte_index: '0,
                       payload_length: '0, running_check: '0};
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go) begin
        st_q        <= st_d;
        wait_q      <= wait_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = res_q.data_byte;
  assign position_o  = res_q.position;
  assign frame_end_o = res_q.frame_end;
  assign status_o    = res_q.status;

endmodule

/* design/xcfr_checker.sv */
// Port-level checks for the frame receiver, bound to the top level
// Depends on xcfr_pkg and xor_checked_frame_receiver_unit
module xcfr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [xcfr_pkg::ByteW-1:0]    data_byte_o,
  input logic [xcfr_pkg::PosW-1:0]     position_o,
  input logic                          frame_end_o,
  input logic [xcfr_pkg::StatusW-1:0]  status_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(position_o) && $stable(frame_end_o) && $stable(status_o))
    else $error("result word changed while stalled");

  // only the in-progress status leaves the frame open
  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o == (status_o != xcfr_pkg::ST_BUSY)))
    else $error("frame end does not match status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == xcfr_pkg::ST_BUSY || status_o == xcfr_pkg::ST_OK
      || status_o == xcfr_pkg::ST_BADHEAD || status_o == xcfr_pkg::ST_TIMEOUT
      || status_o == xcfr_pkg::ST_CHECK))
    else $error("unknown status code");

  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == xcfr_pkg::ST_TIMEOUT |-> data_byte_o == '0)
    else $error("timeout result carries data");

  // a bad head sits at position 0, a fully checked frame ends at position LastOffset or beyond
  a_pos_rules: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != xcfr_pkg::ST_BADHEAD || position_o == '0)
      && ((status_o != xcfr_pkg::ST_OK && status_o != xcfr_pkg::ST_CHECK)
          || position_o >= xcfr_pkg::LastOffset))
    else $error("position inconsistent with status");

endmodule

bind xor_checked_frame_receiver_unit xcfr_checker u_xcfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_byte_o (data_byte_o),
  .position_o  (position_o),
  .frame_end_o (frame_end_o),
  .status_o    (status_o)
);

/* verif/xor_checked_frame_receiver_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for xor_checked_frame_receiver_unit: a directed table, then random frames
// Depends on xcfr_pkg for codes and types; expected words come from an in-bench frame model
module xor_checked_frame_receiver_unit_test;
  import xcfr_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int TimerBits     = TimerBitsDefault;
  localparam int CycleLimit    = 2_000_000;
  localparam int ItemsPerPhase = 250;
  localparam int NumPhases     = 6;
  localparam int DirCfgAt      = 4;
  localparam int DrainCycles   = 6;

  typedef struct {
    logic [KindW-1:0] k;
    logic [ByteW-1:0] b;
    bit               typed;
    result_t          res;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [KindW-1:0]   kind;
  logic [ByteW-1:0]   rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [ByteW-1:0]   data_byte;
  logic [PosW-1:0]    position;
  logic               frame_end;
  logic [StatusW-1:0] status;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;

  // frame model state and its copy of the registers
  phase_e                fr_phase;
  logic [PosW-1:0]       fr_index;
  logic [ByteW-1:0]      fr_len;
  logic [ByteW-1:0]      fr_xor;
  logic [TimerBits-1:0]  fr_wait;
  logic [ByteW-1:0]      cfg_head;
  logic [LimitW-1:0]     cfg_first_lim;
  logic [LimitW-1:0]     cfg_byte_lim;

  result_t expected_words[$];
  int      fail_cnt   = 0;
  int      items_done = 0;
  int      cycle_cnt  = 0;
  bit      feed_burst = 1'b0;

  xor_checked_frame_receiver_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_byte_o (data_byte),
    .position_o  (position),
    .frame_end_o (frame_end),
    .status_o    (status),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic result_t make_result(input logic [ByteW-1:0] d, input logic [PosW-1:0] p,
                                          input logic e, input logic [StatusW-1:0] s);
    result_t r;
    r.data_byte = d;
    r.position  = p;
    r.frame_end = e;
    r.status    = s;
    return r;
  endfunction

  function automatic dir_row_t plain_row(input logic [KindW-1:0] k, input logic [ByteW-1:0] b);
    dir_row_t row;
    row.k     = k;
    row.b     = b;
    row.typed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  function automatic dir_row_t known_row(input logic [KindW-1:0] k, input logic [ByteW-1:0] b,
                                         input logic [ByteW-1:0] d, input logic [PosW-1:0] p,
                                         input logic e, input logic [StatusW-1:0] s);
    dir_row_t row;
    row.k     = k;
    row.b     = b;
    row.typed = 1'b1;
    row.res   = make_result(d, p, e, s);
    return row;
  endfunction

  // advances the frame model by one word, returns 1 when the word yields a result
  function automatic bit frame_model(input logic [KindW-1:0] k, input logic [ByteW-1:0] b,
                                     output result_t r);
    logic [LimitW-1:0] lim;
    r = '0;
    if (k == KIND_START) begin
      fr_phase = PH_HEAD;
      fr_index = '0;
      fr_len   = '0;
      fr_xor   = '0;
      fr_wait  = '0;
      return 1'b0;
    end
    if (fr_phase == PH_IDLE || k == KindUnused) return 1'b0;
    if (k == KIND_TICK) begin
      lim = (fr_phase == PH_HEAD) ? cfg_first_lim : cfg_byte_lim;
      if (fr_wait != '1) fr_wait = fr_wait + 1'b1;
      if (fr_wait > lim) begin
        r = make_result('0, fr_index, 1'b1, ST_TIMEOUT);
        fr_phase = PH_IDLE;
        return 1'b1;
      end
      return 1'b0;
    end
    fr_wait = '0;
    if (fr_phase == PH_HEAD) begin
      if (b != cfg_head) begin
        r = make_result(b, '0, 1'b1, ST_BADHEAD);
        fr_phase = PH_IDLE;
        return 1'b1;
      end
      fr_xor   = b;
      fr_index = 9'd1;
      fr_phase = PH_BODY;
      r = make_result(b, '0, 1'b0, ST_BUSY);
      return 1'b1;
    end
    fr_xor = fr_xor ^ b;
    if (fr_index == LenPos) fr_len = b;
    // last byte sits at L+4
    if (fr_index >= LastOffset && fr_index == {1'b0, fr_len} + LastOffset) begin
      r = make_result(b, fr_index, 1'b1, (fr_xor == '0) ? ST_OK : ST_CHECK);
      fr_phase = PH_IDLE;
      return 1'b1;
    end
    r = make_result(b, fr_index, 1'b0, ST_BUSY);
    fr_index = fr_index + 1'b1;
    return 1'b1;
  endfunction

  task automatic send_word(input logic [KindW-1:0] k, input logic [ByteW-1:0] b,
                           input bit typed, input result_t typed_res);
    int      gap;
    int      r;
    bit      has;
    result_t got;
    r = $urandom_range(0, 99);
    if (feed_burst || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      kind     <= KindW'($urandom);
      rx_byte  <= ByteW'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    has = frame_model(k, b, got);
    if (typed) expected_words.push_back(typed_res);
    else if (has) expected_words.push_back(got);
    items_done++;
  endtask

  // drop valid and wait until nothing is in flight
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_regs(input logic [ByteW-1:0] h, input logic [LimitW-1:0] f,
                            input logic [LimitW-1:0] bl);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_HEAD_BYTE;
    cfg_wdata <= CfgW'(h);
    @(negedge clk);
    cfg_idx   <= REG_FIRST_LIMIT;
    cfg_wdata <= CfgW'(f);
    @(negedge clk);
    cfg_idx   <= REG_BYTE_LIMIT;
    cfg_wdata <= CfgW'(bl);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_head      = h;
    cfg_first_lim = f;
    cfg_byte_lim  = bl;
  endtask

  // one frame with random content, mostly well formed, sometimes with a bad head, cut short or with bad check
  task automatic send_frame();
    logic [ByteW-1:0]  fbytes[$];
    logic [ByteW-1:0]  sum;
    logic [LimitW-1:0] lim;
    int                len;
    int                cut_at;
    int                n;
    int                r;
    feed_burst = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 2) len = $urandom_range(240, 255);
    else if (r < 30) len = $urandom_range(8, 40);
    else len = $urandom_range(0, 7);
    fbytes.push_back(($urandom_range(0, 99) < 88) ? cfg_head : ByteW'($urandom));
    fbytes.push_back(ByteW'($urandom));
    fbytes.push_back(ByteW'($urandom));
    fbytes.push_back(ByteW'(len));
    repeat (len) fbytes.push_back(ByteW'($urandom));
    sum = '0;
    foreach (fbytes[i]) sum = sum ^ fbytes[i];
    fbytes.push_back(($urandom_range(0, 99) < 85) ? sum : ByteW'($urandom));
    cut_at = fbytes.size();
    if ($urandom_range(0, 99) < 8) cut_at = $urandom_range(1, fbytes.size() - 1);
    send_word(KIND_START, ByteW'($urandom), 1'b0, '0);
    for (int i = 0; i < cut_at; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        lim = (i == 0) ? cfg_first_lim : cfg_byte_lim;
        // for limits up to 20, ticks around the limit so waits land on both sides of it
        if (lim <= 20) n = $urandom_range(0, int'(lim) + 2);
        else n = $urandom_range(1, 3);
        repeat (n) send_word(KIND_TICK, ByteW'($urandom), 1'b0, '0);
      end
      send_word(KIND_BYTE, fbytes[i], 1'b0, '0);
    end
    feed_burst = 1'b0;
  endtask

  task automatic flag_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
    fail_cnt++;
  endtask

  // result side: random stalls, with long stretches of ready held high
  initial begin
    int run;
    int stall;
    int r;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      r = $urandom_range(0, 99);
      run = (r < 8) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (run) @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 20) stall = 0;
      else if (r < 88) stall = $urandom_range(1, 3);
      else stall = $urandom_range(15, 50);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: data_byte %0h position %0d status %0d",
               data_byte, position, status);
        fail_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (data_byte !== want.data_byte) flag_field("data_byte", want.data_byte, data_byte);
        if (position !== want.position) flag_field("position", want.position, position);
        if (frame_end !== want.frame_end) flag_field("frame_end", want.frame_end, frame_end);
        if (status !== want.status) flag_field("status", want.status, status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    int       target;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    kind      = KIND_BYTE;
    rx_byte   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_HEAD_BYTE;
    cfg_wdata = '0;
    fr_phase  = PH_IDLE;
    fr_index  = '0;
    fr_len    = '0;
    fr_xor    = '0;
    fr_wait   = '0;
    cfg_head      = HeadByteReset;
    cfg_first_lim = FirstLimitReset;
    cfg_byte_lim  = ByteLimitReset;

    // reset values: head byte is zero
    dir_rows.push_back(plain_row(KIND_START, 8'h00));
    dir_rows.push_back(known_row(KIND_BYTE, 8'h00, 8'h00, 9'd0, 1'b0, ST_BUSY));
    dir_rows.push_back(plain_row(KIND_START, 8'h00));
    dir_rows.push_back(known_row(KIND_BYTE, 8'h01, 8'h01, 9'd0, 1'b1, ST_BADHEAD));
    // from here head 0xff, first-byte limit 1, byte limit 0
    dir_rows.push_back(plain_row(KIND_START, 8'h00));
    dir_rows.push_back(known_row(KIND_BYTE, 8'hAB, 8'hAB, 9'd0, 1'b1, ST_BADHEAD));
    dir_rows.push_back(plain_row(KIND_TICK, 8'h00));
    dir_rows.push_back(plain_row(KindUnused, 8'h00));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'h55));
    dir_rows.push_back(plain_row(KIND_START, 8'h00));
    dir_rows.push_back(plain_row(KIND_TICK, 8'h00));
    dir_rows.push_back(known_row(KIND_TICK, 8'h00, 8'h00, 9'd0, 1'b1, ST_TIMEOUT));
    dir_rows.push_back(plain_row(KIND_START, 8'h00));
    dir_rows.push_back(known_row(KIND_BYTE, 8'hFF, 8'hFF, 9'd0, 1'b0, ST_BUSY));
    dir_rows.push_back(known_row(KIND_TICK, 8'h00, 8'h00, 9'd1, 1'b1, ST_TIMEOUT));
    // shortest frame, length zero, good check
    dir_rows.push_back(plain_row(KIND_START, 8'h00));
    dir_rows.push_back(known_row(KIND_BYTE, 8'hFF, 8'hFF, 9'd0, 1'b0, ST_BUSY));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'h00));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'h12));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'h00));
    dir_rows.push_back(known_row(KIND_BYTE, 8'hED, 8'hED, 9'd4, 1'b1, ST_OK));
    // restart while armed, unused kind mid-frame, then a bad check
    dir_rows.push_back(plain_row(KIND_START, 8'h00));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'hFF));
    dir_rows.push_back(plain_row(KIND_START, 8'h00));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'hFF));
    dir_rows.push_back(plain_row(KindUnused, 8'hFF));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'h80));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'h7F));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'h01));
    dir_rows.push_back(plain_row(KIND_BYTE, 8'h00));
    dir_rows.push_back(known_row(KIND_BYTE, 8'h00, 8'h00, 9'd5, 1'b1, ST_CHECK));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (i == DirCfgAt) write_regs(8'hFF, 32'd1, 32'd0);
      send_word(dir_rows[i].k, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: write_regs(HeadByteReset, FirstLimitReset, ByteLimitReset);
        1: write_regs(8'hA5, 32'd3, 32'd2);
        2: write_regs(8'hFF, 32'd0, 32'd0);
        3: write_regs(8'h3C, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: write_regs(8'h00, 32'd6, 32'd4);
        default: write_regs(ByteW'($urandom), $urandom_range(0, 12), $urandom_range(0, 12));
      endcase
      target = items_done + ItemsPerPhase;
      while (items_done < target) begin
        if ($urandom_range(0, 99) < 15) begin
          // noise: stray words of any kind, including starts that break frames
          repeat ($urandom_range(1, 6))
            send_word(KindW'($urandom_range(0, 3)), ByteW'($urandom), 1'b0, '0);
        end else begin
          send_frame();
        end
      end
    end

    settle();
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
